[hw/rtl/wpgt_pkg.sv]
`timescale 1ns / 1ps

package wpgt_pkg;

    // Default sizes of the block.
    localparam int GATEWAY_COUNT_DEF  = 8;
    localparam int NEIGHBOR_COUNT_DEF = 4;
    localparam int BW_BITS_DEF        = 20;

    // Fixed field widths of the input and result words.
    localparam int OP_W        = 2;
    localparam int SLOT_FIELD_W = 2;
    localparam int GW_FIELD_W  = 3;
    localparam int CFG_INDEX_W = 3;

    // Bandwidth reported after reset when the table holds no positive entry.
    localparam int DEFAULT_BW_RESET = 200;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_ADVERT = 2'd2
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINK_BW_N0 = 3'd0,
        CFG_LINK_BW_N1 = 3'd1,
        CFG_LINK_BW_N2 = 3'd2,
        CFG_LINK_BW_N3 = 3'd3,
        CFG_KNOWN_MASK = 3'd4,
        CFG_DEFAULT_BW = 3'd5
    } cfg_index_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
        logic scan;
        logic drain;
        logic publish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_entry;
        logic last_item;
        logic scan_done;
        logic out_free;
    } status_t;

endpackage

[hw/rtl/wpgt_ctrl.sv]
`timescale 1ns / 1ps

module wpgt_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  wpgt_pkg::status_t  status,
    output wpgt_pkg::cmd_t     cmd
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_UPDATE  = 5'b00010,
        ST_SCAN    = 5'b00100,
        ST_DRAIN   = 5'b01000,
        ST_PUBLISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        cmd.capture = accept;
        cmd.update  = (state_reg == ST_UPDATE);
        cmd.scan    = (state_reg == ST_SCAN);
        cmd.drain   = (state_reg == ST_DRAIN);
        cmd.publish = (state_reg == ST_PUBLISH) && status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.in_entry)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = status.last_item ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_PUBLISH;
            end
            ST_PUBLISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/wpgt_datapath.sv]
`timescale 1ns / 1ps

module wpgt_datapath
#(
    parameter int GATEWAY_COUNT  = wpgt_pkg::GATEWAY_COUNT_DEF,
    parameter int NEIGHBOR_COUNT = wpgt_pkg::NEIGHBOR_COUNT_DEF,
    parameter int BW_BITS        = wpgt_pkg::BW_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [wpgt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [BW_BITS-1:0]                 cfg_data,
    input  logic [wpgt_pkg::OP_W-1:0]          operation,
    input  logic [wpgt_pkg::SLOT_FIELD_W-1:0]  neighbor_slot,
    input  logic [wpgt_pkg::GW_FIELD_W-1:0]    gateway_index,
    input  logic [BW_BITS-1:0]                 bw_value,
    input  logic                               last_in_batch,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               table_changed,
    output logic [wpgt_pkg::GW_FIELD_W-1:0]    best_gateway,
    output logic [BW_BITS-1:0]                 best_bw_report,
    input  wpgt_pkg::cmd_t                     cmd,
    output wpgt_pkg::status_t                  status
);

    localparam int IDX_W  = $clog2(GATEWAY_COUNT);
    localparam int SLOT_W = (NEIGHBOR_COUNT > 1) ? $clog2(NEIGHBOR_COUNT) : 1;

    // Configuration.
    logic [BW_BITS-1:0]        link_bw_reg [NEIGHBOR_COUNT];
    logic [NEIGHBOR_COUNT-1:0] known_mask_reg;
    logic [BW_BITS-1:0]        default_bw_reg;

    // Captured input word.
    logic [wpgt_pkg::OP_W-1:0]         op_reg;
    logic [wpgt_pkg::SLOT_FIELD_W-1:0] slot_reg;
    logic [IDX_W-1:0]                  gw_reg;
    logic                              in_range_reg;
    logic [BW_BITS-1:0]                bw_reg;
    logic                              last_reg;

    // Table: values in memory, valid bits in flip-flops.
    logic [BW_BITS-1:0]       bw_mem [GATEWAY_COUNT];
    logic [BW_BITS-1:0]       rd_data_reg;
    logic [IDX_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [BW_BITS-1:0]       wr_data;
    logic [GATEWAY_COUNT-1:0] valid_reg;
    logic [GATEWAY_COUNT-1:0] valid_next;

    // Batch and best-gateway state.
    logic                            batch_changed_reg;
    logic                            batch_changed_next;
    logic [wpgt_pkg::GW_FIELD_W-1:0] best_index_reg;
    logic [wpgt_pkg::GW_FIELD_W-1:0] best_index_next;
    logic [BW_BITS-1:0]              best_bw_reg;
    logic [BW_BITS-1:0]              best_bw_next;

    // Scan walker.
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] scan_idx_next;
    logic             pend_reg;
    logic             pend_next;
    logic [IDX_W-1:0] pend_idx_reg;

    // Result register.
    logic                            out_valid_reg;
    logic                            out_changed_reg;
    logic [wpgt_pkg::GW_FIELD_W-1:0] out_gateway_reg;
    logic [BW_BITS-1:0]              out_bw_reg;

    logic               known;
    logic [BW_BITS-1:0] capped;
    logic               take_entry;

    assign status.in_entry  = (operation == wpgt_pkg::OP_LOAD)
                           || (operation == wpgt_pkg::OP_ADVERT);
    assign status.last_item = last_reg;
    assign status.scan_done = (scan_idx_reg == IDX_W'(GATEWAY_COUNT - 1));
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign table_changed  = out_changed_reg;
    assign best_gateway   = out_gateway_reg;
    assign best_bw_report = out_bw_reg;

    // Configuration writes. Link slots beyond the neighbor count are never
    // capped, so their writes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NEIGHBOR_COUNT; i++)
            begin
                link_bw_reg[i] <= '0;
            end
            known_mask_reg <= '0;
            default_bw_reg <= BW_BITS'(wpgt_pkg::DEFAULT_BW_RESET);
        end
        else if (cfg_write)
        begin
            if ((cfg_index <= wpgt_pkg::CFG_LINK_BW_N3)
                && (32'(cfg_index) < 32'(NEIGHBOR_COUNT)))
            begin
                link_bw_reg[SLOT_W'(cfg_index)] <= cfg_data;
            end
            else if (cfg_index == wpgt_pkg::CFG_KNOWN_MASK)
            begin
                known_mask_reg <= NEIGHBOR_COUNT'(cfg_data);
            end
            else if (cfg_index == wpgt_pkg::CFG_DEFAULT_BW)
            begin
                default_bw_reg <= cfg_data;
            end
        end
    end

    // Input capture.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= operation;
            slot_reg     <= neighbor_slot;
            gw_reg       <= IDX_W'(gateway_index);
            in_range_reg <= (32'(gateway_index) < 32'(GATEWAY_COUNT));
            bw_reg       <= bw_value;
            last_reg     <= last_in_batch;
        end
    end

    // Advertised value capped by the link of a known sending neighbor.
    always_comb
    begin
        known  = (32'(slot_reg) < 32'(NEIGHBOR_COUNT))
              && known_mask_reg[SLOT_W'(slot_reg)];
        capped = bw_reg;
        if (known && (link_bw_reg[SLOT_W'(slot_reg)] < bw_reg))
        begin
            capped = link_bw_reg[SLOT_W'(slot_reg)];
        end
        take_entry = (op_reg == wpgt_pkg::OP_LOAD)
                  || !valid_reg[gw_reg] || (capped > rd_data_reg);
    end

    assign wr_en   = cmd.update && in_range_reg && take_entry;
    assign wr_data = (op_reg == wpgt_pkg::OP_LOAD) ? bw_reg : capped;
    assign rd_addr = cmd.scan ? scan_idx_reg : IDX_W'(gateway_index);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bw_mem[gw_reg] <= wr_data;
        end
        rd_data_reg <= bw_mem[rd_addr];
    end

    always_comb
    begin
        valid_next         = valid_reg;
        batch_changed_next = batch_changed_reg;
        best_index_next    = best_index_reg;
        best_bw_next       = best_bw_reg;
        scan_idx_next      = scan_idx_reg;
        pend_next          = pend_reg;

        if (cmd.capture && (operation == wpgt_pkg::OP_CLEAR))
        begin
            valid_next = '0;
        end

        if (wr_en)
        begin
            valid_next[gw_reg] = 1'b1;
            batch_changed_next = 1'b1;
        end

        if (cmd.update && last_reg)
        begin
            scan_idx_next = '0;
            pend_next     = 1'b0;
            best_bw_next  = '0;
        end

        // The memory read is registered, so each step
        // compares the entry that was addressed in the previous step.
        if ((cmd.scan || cmd.drain) && pend_reg && valid_reg[pend_idx_reg]
            && (rd_data_reg > best_bw_reg))
        begin
            best_bw_next    = rd_data_reg;
            best_index_next = wpgt_pkg::GW_FIELD_W'(pend_idx_reg);
        end

        if (cmd.scan)
        begin
            scan_idx_next = scan_idx_reg + IDX_W'(1);
            pend_next     = 1'b1;
        end

        if (cmd.drain)
        begin
            pend_next = 1'b0;
        end

        if (cmd.publish)
        begin
            batch_changed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg         <= '0;
            batch_changed_reg <= 1'b0;
            best_index_reg    <= '0;
            best_bw_reg       <= '0;
            scan_idx_reg      <= '0;
            pend_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            valid_reg         <= valid_next;
            batch_changed_reg <= batch_changed_next;
            best_index_reg    <= best_index_next;
            best_bw_reg       <= best_bw_next;
            scan_idx_reg      <= scan_idx_next;
            pend_reg          <= pend_next;
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            pend_idx_reg <= scan_idx_reg;
        end
        if (cmd.publish)
        begin
            out_changed_reg <= batch_changed_reg;
            out_gateway_reg <= best_index_reg;
            out_bw_reg      <= (best_bw_reg != '0) ? best_bw_reg : default_bw_reg;
        end
    end

endmodule

[hw/rtl/widest_path_gateway_table.sv]
`timescale 1ns / 1ps

// Widest-path gateway table. The block keeps the bottleneck bandwidth, in Mbps,
// of the best known path to each ground gateway. A clear word empties the
// table and a load word overwrites one local entry; an advertisement word is
// capped by the link bandwidth of its sending neighbor (unless that neighbor
// is unknown) and is stored only if the entry is empty or the new value is
// larger. The last load or advertisement word of a batch starts a rescan and
// yields one result word: whether the batch changed the table, the best
// gateway (lowest index on ties, kept from before if nothing is positive),
// and its bandwidth, or default_bw when that is zero. A clear word or a word
// with the unused operation code needs only its capture step. A load or
// advertisement word that ends no batch is captured and then updates the
// table. One that ends a batch goes through capture, update, one scan step
// per entry, a step to compare the last entry read and a publish step. The
// rescan is the longest part, since it walks the table's single memory read
// port one entry per cycle. A finished result waits in an output register
// while the next word is taken; a batch end that finds that register still
// full holds off its publish step until the receiver takes the waiting
// result. Configuration must be written only while the block is idle; the
// block itself does not enforce this.

module widest_path_gateway_table
#(
    parameter int GATEWAY_COUNT  = wpgt_pkg::GATEWAY_COUNT_DEF,
    parameter int NEIGHBOR_COUNT = wpgt_pkg::NEIGHBOR_COUNT_DEF,
    parameter int BW_BITS        = wpgt_pkg::BW_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    // Configuration write port.
    input  logic                               cfg_write,
    input  logic [wpgt_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [BW_BITS-1:0]                 cfg_data,

    // Input word channel.
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [wpgt_pkg::OP_W-1:0]          operation,
    input  logic [wpgt_pkg::SLOT_FIELD_W-1:0]  neighbor_slot,
    input  logic [wpgt_pkg::GW_FIELD_W-1:0]    gateway_index,
    input  logic [BW_BITS-1:0]                 bw_value,
    input  logic                               last_in_batch,

    // Result word channel.
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               table_changed,
    output logic [wpgt_pkg::GW_FIELD_W-1:0]    best_gateway,
    output logic [BW_BITS-1:0]                 best_bw_report
);

    // The controller sequences capture, update, the rescan and the report;
    // the datapath holds the table, the configuration and the result word.
    wpgt_pkg::cmd_t    cmd;
    wpgt_pkg::status_t status;

    wpgt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    wpgt_datapath
    #(
        .GATEWAY_COUNT  (GATEWAY_COUNT),
        .NEIGHBOR_COUNT (NEIGHBOR_COUNT),
        .BW_BITS        (BW_BITS)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .operation      (operation),
        .neighbor_slot  (neighbor_slot),
        .gateway_index  (gateway_index),
        .bw_value       (bw_value),
        .last_in_batch  (last_in_batch),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .table_changed  (table_changed),
        .best_gateway   (best_gateway),
        .best_bw_report (best_bw_report),
        .cmd            (cmd),
        .status         (status)
    );

endmodule
